/* src/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define RTPSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RTPSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/rtpse_pkg.sv */
`timescale 1ns / 1ps
package rtpse_pkg;

   localparam int unsigned CsrIndexWidth = 8;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type RegProbationLen     = csr_index_type'(0);
   localparam csr_index_type RegMaxDropout       = csr_index_type'(1);
   localparam csr_index_type RegMaxMisorder      = csr_index_type'(2);
   localparam csr_index_type RegInitialProbation = csr_index_type'(3);

   localparam logic [7:0]  ProbationLenReset     = 8'd2;
   localparam logic [15:0] MaxDropoutReset       = 16'd3000;
   localparam logic [15:0] MaxMisorderReset      = 16'd100;
   localparam logic [7:0]  InitialProbationReset = 8'd0;

   typedef struct packed {
      logic [31:0] extended_seq;
      logic        is_valid;
      logic        did_resync;
      logic        is_stable;
   } result_type;

endpackage

/* src/rtp_sequence_extender.sv */
// Results are registered: in the result register, or in the skid register while that one is held.
// Throughput: one request word per cycle while req_stall is low; the per-packet update is one compare-and-update pass.
// A two-entry output (result register plus skid register) keeps req_stall low while one
// result waits; req_stall rises only when both entries are full.
// Reset (synchronous, active high) clears the tracking state, loads the register defaults
// and empties the output; the block is ready in the cycle after reset drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtp_sequence_extender
   import rtpse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_seq_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_extended_seq,
   output logic                rsp_is_valid,
   output logic                rsp_did_resync,
   output logic                rsp_is_stable,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]         csr_data
);

   logic [7:0]  probation_len_ff;
   logic [15:0] max_dropout_ff;
   logic [15:0] max_misorder_ff;
   logic [7:0]  initial_probation_ff;

   logic        started_ff, started_in;
   logic [15:0] highest_seq_ff, highest_seq_in;
   logic [15:0] wrap_cycles_ff, wrap_cycles_in;
   logic [15:0] bad_candidate_ff, bad_candidate_in;
   logic        bad_candidate_valid_ff, bad_candidate_valid_in;
   logic [7:0]  probation_left_ff, probation_left_in;

   result_type  result_in;
   result_type  out_ff;
   result_type  skid_ff;
   logic        out_valid_ff;
   logic        skid_valid_ff;

   logic        accept;
   logic        pop;
   logic        csr_write;
   logic [15:0] delta;
   logic [16:0] misorder_limit;
   logic [7:0]  probation_dec;

   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = skid_valid_ff;

   assign rsp_valid        = out_valid_ff;
   assign rsp_extended_seq = out_ff.extended_seq;
   assign rsp_is_valid     = out_ff.is_valid;
   assign rsp_did_resync   = out_ff.did_resync;
   assign rsp_is_stable    = out_ff.is_stable;

   assign delta          = req_seq_number - highest_seq_ff;
   assign misorder_limit = 17'h10000 - {1'b0, max_misorder_ff};
   assign probation_dec  = probation_left_ff - 8'd1;

   always_comb begin
      started_in             = started_ff;
      highest_seq_in         = highest_seq_ff;
      wrap_cycles_in         = wrap_cycles_ff;
      bad_candidate_in       = bad_candidate_ff;
      bad_candidate_valid_in = bad_candidate_valid_ff;
      probation_left_in      = probation_left_ff;
      result_in.is_valid     = 1'b1;
      result_in.did_resync   = 1'b0;
      result_in.is_stable    = 1'b1;

      if (!started_ff) begin
         started_in             = 1'b1;
         highest_seq_in         = req_seq_number;
         wrap_cycles_in         = '0;
         bad_candidate_in       = '0;
         bad_candidate_valid_in = 1'b0;
         result_in.is_stable    = 1'b0;
      end else if (probation_left_ff != 8'd0) begin
         highest_seq_in = req_seq_number;
         if (req_seq_number == highest_seq_ff + 16'd1) begin
            probation_left_in = probation_dec;
            // Probation is over: the counter starts fresh from this packet.
            if (probation_dec == 8'd0) begin
               wrap_cycles_in         = '0;
               bad_candidate_in       = '0;
               bad_candidate_valid_in = 1'b0;
               result_in.is_stable    = 1'b0;
            end
         end else begin
            probation_left_in = probation_len_ff - 8'd1;
         end
      end else if (delta <= max_dropout_ff) begin
         if (req_seq_number < highest_seq_ff) begin
            wrap_cycles_in = wrap_cycles_ff + 16'd1;
         end
         highest_seq_in = req_seq_number;
      end else if ({1'b0, delta} <= misorder_limit) begin
         result_in.is_valid = 1'b0;
         // A second packet continuing the same large jump resynchronizes the stream.
         if (bad_candidate_valid_ff && (req_seq_number == bad_candidate_ff)) begin
            highest_seq_in         = req_seq_number;
            wrap_cycles_in         = '0;
            bad_candidate_in       = '0;
            bad_candidate_valid_in = 1'b0;
            result_in.did_resync   = 1'b1;
            result_in.is_stable    = 1'b0;
         end else begin
            bad_candidate_in       = req_seq_number + 16'd1;
            bad_candidate_valid_in = 1'b1;
         end
      end

      result_in.extended_seq = {wrap_cycles_in, req_seq_number};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probation_len_ff     <= ProbationLenReset;
         max_dropout_ff       <= MaxDropoutReset;
         max_misorder_ff      <= MaxMisorderReset;
         initial_probation_ff <= InitialProbationReset;
      end else if (csr_write) begin
         unique case (csr_index)
            RegProbationLen:     probation_len_ff     <= csr_data[7:0];
            RegMaxDropout:       max_dropout_ff       <= csr_data;
            RegMaxMisorder:      max_misorder_ff      <= csr_data;
            RegInitialProbation: initial_probation_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff             <= 1'b0;
         highest_seq_ff         <= '0;
         wrap_cycles_ff         <= '0;
         bad_candidate_ff       <= '0;
         bad_candidate_valid_ff <= 1'b0;
         probation_left_ff      <= InitialProbationReset;
      end else if (accept) begin
         started_ff             <= started_in;
         highest_seq_ff         <= highest_seq_in;
         wrap_cycles_ff         <= wrap_cycles_in;
         bad_candidate_ff       <= bad_candidate_in;
         bad_candidate_valid_ff <= bad_candidate_valid_in;
         probation_left_ff      <= probation_left_in;
      end else if (csr_write && (csr_index == RegInitialProbation) && !started_ff) begin
         // Before the first packet, a new initial probation also reloads the count.
         probation_left_ff <= csr_data[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= result_in;
         end else begin
            skid_ff <= result_in;
         end
      end
   end

   `RTPSE_ASSERT(skid_needs_out, !skid_valid_ff || out_valid_ff, "skid word without output word")
   `RTPSE_ASSERT_NEXT(accept_gives_result, accept, out_valid_ff, "accepted word gave no result")
   `RTPSE_ASSERT_NEXT(started_sticks, started_ff, started_ff, "started flag dropped")
   `RTPSE_ASSERT_NEXT(wrap_needs_accept, !accept, $stable(wrap_cycles_ff), "wrap count moved")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import rtpse_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int RandomPhaseWords = 220;
   localparam csr_index_type UnusedIndexLow  = csr_index_type'(4);
   localparam csr_index_type UnusedIndexHigh = csr_index_type'(255);

   // Tracks the expected extended sequence of every packet word taken by the block.
   class ext_board;
      logic [7:0]  min_seq;
      logic [15:0] max_drop;
      logic [15:0] max_mis;
      logic [7:0]  init_prob;
      bit          started;
      logic [15:0] highest;
      logic [15:0] wraps;
      logic [15:0] cand;
      bit          cand_valid;
      logic [7:0]  probation;
      result_type  pending_results[$];
      int          errors;

      function new();
         min_seq = ProbationLenReset;
         max_drop = MaxDropoutReset;
         max_mis = MaxMisorderReset;
         init_prob = InitialProbationReset;
         started = 0;
         highest = '0;
         wraps = '0;
         cand = '0;
         cand_valid = 0;
         probation = InitialProbationReset;
         errors = 0;
      endfunction

      function void restart(logic [15:0] s);
         highest = s;
         wraps = '0;
         cand = '0;
         cand_valid = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] d);
         case (idx)
            RegProbationLen: min_seq = d[7:0];
            RegMaxDropout: max_drop = d;
            RegMaxMisorder: max_mis = d;
            RegInitialProbation: begin
               init_prob = d[7:0];
               // Before the first packet the probation count follows the register.
               if (!started) probation = d[7:0];
            end
            default: ;
         endcase
      endfunction

      function void note_packet(logic [15:0] s);
         result_type  r;
         logic [15:0] delta;
         logic [15:0] next_seq;
         r.is_valid = 1'b1;
         r.did_resync = 1'b0;
         r.is_stable = 1'b1;
         delta = s - highest;
         next_seq = highest + 16'd1;
         if (!started) begin
            restart(s);
            started = 1;
            r.is_stable = 1'b0;
         end else if (probation != 8'd0) begin
            if (s == next_seq) begin
               probation = probation - 8'd1;
               highest = s;
               if (probation == 8'd0) begin
                  restart(s);
                  r.is_stable = 1'b0;
               end
            end else begin
               probation = min_seq - 8'd1;
               highest = s;
            end
         end else if (delta <= max_drop) begin
            if (s < highest) wraps = wraps + 16'd1;
            highest = s;
         end else if ({1'b0, delta} <= 17'h10000 - {1'b0, max_mis}) begin
            r.is_valid = 1'b0;
            if (cand_valid && s == cand) begin
               restart(s);
               r.did_resync = 1'b1;
               r.is_stable = 1'b0;
            end else begin
               cand = s + 16'd1;
               cand_valid = 1;
            end
         end
         r.extended_seq = {wraps, s};
         pending_results.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result word %h with no packet pending", got));
         end else begin
            want = pending_results.pop_front();
            if (got.extended_seq !== want.extended_seq)
               report($sformatf("extended_seq %h, expected %h",
                                got.extended_seq, want.extended_seq));
            if (got.is_valid !== want.is_valid)
               report($sformatf("is_valid %b, expected %b", got.is_valid, want.is_valid));
            if (got.did_resync !== want.did_resync)
               report($sformatf("did_resync %b, expected %b",
                                got.did_resync, want.did_resync));
            if (got.is_stable !== want.is_stable)
               report($sformatf("is_stable %b, expected %b", got.is_stable, want.is_stable));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [15:0]         req_seq_number;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [31:0]         rsp_extended_seq;
   logic                rsp_is_valid;
   logic                rsp_did_resync;
   logic                rsp_is_stable;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [15:0]         csr_data;

   ext_board    board = new();
   int          packets_in;
   int          idle_cycles;
   logic [15:0] gen_cur;
   int          gen_drop;
   int          gen_mis;

   rtp_sequence_extender u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_seq_number   (req_seq_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_extended_seq (rsp_extended_seq),
      .rsp_is_valid     (rsp_is_valid),
      .rsp_did_resync   (rsp_did_resync),
      .rsp_is_stable    (rsp_is_stable),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // No idling on either side while this window of packets goes through.
   function automatic bit quiet_window();
      return packets_in >= 700 && packets_in < 900;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result(result_type'{rsp_extended_seq, rsp_is_valid,
                                            rsp_did_resync, rsp_is_stable});
         if (req_valid && !req_stall) begin
            board.note_packet(req_seq_number);
            packets_in <= packets_in + 1;
         end
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off to back the block up.
   initial begin
      int hold;
      bit held;
      rsp_stall <= 1'b0;
      hold = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (!held && packets_in >= 300) begin
            held = 1;
            hold = 80;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else if (quiet_window()) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 16);
         end
      end
   end

   task automatic send_word(input logic [15:0] s);
      while (!quiet_window() && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_seq_number <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // The first edge lets the monitor note the last accepted word before the count is read.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly in-order traffic with loss gaps, reorders, and large jumps that are
   // often continued by the next word so that the counter resyncs.
   task automatic send_stream(input int count);
      int          kind;
      int          step;
      int          lo;
      int          hi;
      int          off;
      bit          follow;
      logic [15:0] jump;
      follow = 0;
      jump = '0;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         if (follow) begin
            send_word(jump);
            gen_cur = jump;
            follow = 0;
         end else if (kind < 62) begin
            if ($urandom_range(3) == 0) step = $urandom_range(gen_drop, 0);
            else step = $urandom_range((gen_drop < 4) ? gen_drop : 4, 0);
            gen_cur = gen_cur + 16'(step);
            send_word(gen_cur);
         end else if (kind < 74) begin
            off = $urandom_range((gen_mis < 1) ? 1 : gen_mis, 1);
            send_word(gen_cur - 16'(off));
         end else if (kind < 90) begin
            lo = gen_drop + 1;
            hi = 65536 - gen_mis;
            if (hi > 65535) hi = 65535;
            if (lo <= hi) begin
               jump = gen_cur + 16'($urandom_range(hi, lo));
               send_word(jump);
               if ($urandom_range(99) < 65) begin
                  follow = 1;
                  jump = jump + 16'd1;
               end
            end else begin
               send_word(16'($urandom));
            end
         end else if (kind < 94) begin
            send_word(gen_cur);
         end else begin
            send_word(16'($urandom));
         end
      end
   endtask

   task automatic run_phase(input int drop, input int mis, input logic [7:0] probation_len,
                            input int count);
      wait_idle();
      csr_write(RegMaxDropout, 16'(drop));
      csr_write(RegMaxMisorder, 16'(mis));
      csr_write(RegProbationLen, {8'h00, probation_len});
      csr_write(RegInitialProbation, 16'($urandom_range(255)));
      gen_drop = drop;
      gen_mis = mis;
      gen_cur = board.highest;
      send_stream(count);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_seq_number <= '0;
      csr_valid <= 1'b0;
      csr_index <= RegProbationLen;
      csr_data <= '0;
      packets_in <= 0;
      idle_cycles <= 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Probation: loaded before the first packet, upper data bits ignored.
      csr_write(RegProbationLen, 16'h0000);
      csr_write(RegInitialProbation, 16'h00FF);
      csr_write(RegInitialProbation, 16'h1203);
      // First packet, in-order across the 16-bit wrap, then out of order with a
      // zero minimum so the probation count reloads as 255.
      send_word(16'hFFFF); send_word(16'd0); send_word(16'd7);
      wait_idle();
      csr_write(RegProbationLen, 16'd2);
      // Out of order reloads one, then in order ends probation with a restart.
      send_word(16'd8); send_word(16'd20); send_word(16'd21);
      // Loss gap at the dropout limit and just past it, then the resync.
      send_word(16'd22); send_word(16'd3022); send_word(16'd6023); send_word(16'd6024);
      // Duplicate, a jump at the edge of the misorder window, then just inside it.
      send_word(16'd6024); send_word(16'd5924); send_word(16'd5925);
      wait_idle();
      // Widest dropout: every step is a gap, and wraps add cycles.
      csr_write(RegMaxDropout, 16'hFFFF);
      send_word(16'd65000); send_word(16'd10); send_word(16'hFFFF); send_word(16'd0);
      wait_idle();
      // Zero dropout and zero misorder: any move is a large jump.
      csr_write(RegMaxDropout, 16'd0);
      csr_write(RegMaxMisorder, 16'd0);
      send_word(16'd0); send_word(16'd5); send_word(16'd6);
      wait_idle();
      // Widest misorder window: only a step of one is a large jump.
      csr_write(RegMaxMisorder, 16'hFFFF);
      send_word(16'd7); send_word(16'd100); send_word(16'd8);
      wait_idle();
      // Writes past the register list, and a probation write once started.
      csr_write(UnusedIndexLow, 16'h0001);
      csr_write(UnusedIndexHigh, 16'hFFFF);
      csr_write(RegInitialProbation, 16'h00FF);

      run_phase(3000, 100, 8'd255, RandomPhaseWords);
      run_phase(65535, 0, 8'd1, RandomPhaseWords);
      run_phase(0, 0, 8'd1, RandomPhaseWords);
      run_phase(200, 65535, 8'd255, RandomPhaseWords);
      run_phase($urandom_range(65535), $urandom_range(65535), 8'($urandom_range(255, 1)),
                RandomPhaseWords);
      run_phase(3000, 100, 8'd2, RandomPhaseWords);

      wait_idle();
      repeat (4) @(posedge clock);
      if (board.pending_results.size() != 0) board.report("results never arrived");
      if (board.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

/* rtp_sequence_extender.f */
+incdir+src
src/rtpse_pkg.sv
src/rtp_sequence_extender.sv
tb/tb.sv
